// ===== sv/cll_pkg.sv =====
// shared types and constants of the cursor linked list engine
`default_nettype none

package cll_pkg;

    localparam int OP_W   = 2;
    localparam int DATA_W = 8;
    localparam int ST_W   = 2;
    localparam int FLD_W  = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 2'd0,
        OP_DELETE  = 2'd1,
        OP_REPLACE = 2'd2,
        OP_INSERT  = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_DUP  = 2'd2,
        ST_RSVD = 2'd3
    } t_status;

    typedef enum logic [7:0] {
        S_INIT = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_FREE = 8'b0000_0100,
        S_WALK = 8'b0000_1000,
        S_FIX  = 8'b0001_0000,
        S_INS1 = 8'b0010_0000,
        S_INS2 = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

endpackage

`default_nettype wire

// ===== sv/cursor_linked_list_engine_top.sv =====
// top level of the cursor linked list engine: sequencer, slot stores and result register
//
// One list of bytes and one free list share SLOT_COUNT slots held in two
// memories (values and links); slot SLOT_COUNT stands for the null link.
// After reset a clearing pass chains every slot into the free list, and
// no request is taken until it ends. Each request is then handled by a
// sequencer that walks the list one slot per cycle, bound by the single
// read port of the link memory: push front reads the free head and writes
// the new slot at the front, delete and replace walk the whole list (delete
// then fixes the last kept link), and sorted insert reads the free head,
// seeks the insertion point and links the new slot in (full store or
// duplicate end sooner). One request is worked on at a time; the result
// waits in an output register, so a new request can be taken before the
// previous result is collected.
`default_nettype none

module cursor_linked_list_engine_top
    import cll_pkg::*;
#(
    parameter int SLOT_COUNT = 128
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // [1:0] operation, [9:2] value, [17:10] replacement
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [1:0] status, [9:2] affected_count, [17:10] head_slot, [25:18] free_slot
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW = $clog2(SLOT_COUNT + 1);
    localparam logic [PW-1:0] NIL = PW'(SLOT_COUNT);
    localparam logic [PW-1:0] LAST = PW'(SLOT_COUNT - 1);

    t_state          r_state, n_state;
    t_op             r_op, n_op;
    logic [DATA_W-1:0] r_value, n_value;
    logic [DATA_W-1:0] r_repl, n_repl;
    t_status         r_status, n_status;
    logic [PW-1:0]   r_count, n_count;
    logic [PW-1:0]   r_head, n_head;
    logic [PW-1:0]   r_free, n_free;
    logic [PW-1:0]   r_free_next, n_free_next;
    logic [PW-1:0]   r_cur, n_cur;
    logic [PW-1:0]   r_prev, n_prev;
    logic            r_dirty, n_dirty;
    logic            r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic              val_we, link_we;
    logic [AW-1:0]     val_waddr, link_waddr, rd_addr;
    logic [DATA_W-1:0] val_wdata, rd_val;
    logic [PW-1:0]     link_wdata, rd_link;
    logic              in_fire;

    cll_ram #(.WIDTH(DATA_W), .DEPTH(SLOT_COUNT)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_val)
    );

    cll_ram #(.WIDTH(PW), .DEPTH(SLOT_COUNT)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_link)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_value     = r_value;
        n_repl      = r_repl;
        n_status    = r_status;
        n_count     = r_count;
        n_head      = r_head;
        n_free      = r_free;
        n_free_next = r_free_next;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_dirty     = r_dirty;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        val_we      = 1'b0;
        val_waddr   = r_free[AW-1:0];
        val_wdata   = r_value;
        link_we     = 1'b0;
        link_waddr  = r_cur[AW-1:0];
        link_wdata  = r_free;
        rd_addr     = r_cur[AW-1:0];

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                link_we    = 1'b1;
                link_waddr = r_cur[AW-1:0];
                link_wdata = r_cur + PW'(1);
                n_cur      = r_cur + PW'(1);
                if (r_cur == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_op     = t_op'(s_axis_tdata[1:0]);
                    n_value  = s_axis_tdata[9:2];
                    n_repl   = s_axis_tdata[17:10];
                    n_status = ST_DONE;
                    n_count  = '0;
                    n_prev   = NIL;
                    n_dirty  = 1'b0;
                    if (t_op'(s_axis_tdata[1:0]) inside {OP_PUSH, OP_INSERT}) begin
                        if (r_free == NIL) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            rd_addr = r_free[AW-1:0];
                            n_state = S_FREE;
                        end
                    end else begin
                        n_cur   = r_head;
                        rd_addr = r_head[AW-1:0];
                        n_state = (r_head == NIL) ? S_DONE : S_WALK;
                    end
                end
            end
            S_FREE: begin
                n_free_next = rd_link;
                if (r_op == OP_PUSH) begin
                    val_we     = 1'b1;
                    val_waddr  = r_free[AW-1:0];
                    val_wdata  = r_value;
                    link_we    = 1'b1;
                    link_waddr = r_free[AW-1:0];
                    link_wdata = r_head;
                    n_head     = r_free;
                    n_free     = rd_link;
                    n_count    = PW'(1);
                    n_state    = S_DONE;
                end else begin
                    n_cur   = r_head;
                    rd_addr = r_head[AW-1:0];
                    n_state = (r_head == NIL) ? S_INS1 : S_WALK;
                end
            end
            S_WALK: begin
                rd_addr = rd_link[AW-1:0];
                n_cur   = rd_link;
                case (r_op)
                    OP_DELETE: begin
                        if (rd_val == r_value) begin
                            link_we    = 1'b1;
                            link_waddr = r_cur[AW-1:0];
                            link_wdata = r_free;
                            n_free     = r_cur;
                            n_count    = r_count + PW'(1);
                            if (r_prev == NIL) begin
                                n_head = rd_link;
                            end else begin
                                n_dirty = 1'b1;
                            end
                        end else begin
                            if (r_dirty) begin
                                link_we    = 1'b1;
                                link_waddr = r_prev[AW-1:0];
                                link_wdata = r_cur;
                                n_dirty    = 1'b0;
                            end
                            n_prev = r_cur;
                        end
                        if (rd_link == NIL) begin
                            n_state = S_FIX;
                        end
                    end
                    OP_REPLACE: begin
                        if (rd_val == r_value) begin
                            val_we    = 1'b1;
                            val_waddr = r_cur[AW-1:0];
                            val_wdata = r_repl;
                            n_count   = r_count + PW'(1);
                        end
                        if (rd_link == NIL) begin
                            n_state = S_DONE;
                        end
                    end
                    OP_INSERT: begin
                        if (rd_val < r_value) begin
                            n_prev = r_cur;
                            if (rd_link == NIL) begin
                                n_state = S_INS1;
                            end
                        end else if (rd_val == r_value) begin
                            n_cur    = r_cur;
                            n_status = ST_DUP;
                            n_state  = S_DONE;
                        end else begin
                            n_cur   = r_cur;
                            n_state = S_INS1;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_FIX: begin
                if (r_dirty) begin
                    link_we    = 1'b1;
                    link_waddr = r_prev[AW-1:0];
                    link_wdata = NIL;
                    n_dirty    = 1'b0;
                end
                n_state = S_DONE;
            end
            S_INS1: begin
                if (r_prev != NIL) begin
                    link_we    = 1'b1;
                    link_waddr = r_prev[AW-1:0];
                    link_wdata = r_free;
                end
                n_state = S_INS2;
            end
            S_INS2: begin
                val_we     = 1'b1;
                val_waddr  = r_free[AW-1:0];
                val_wdata  = r_value;
                link_we    = 1'b1;
                link_waddr = r_free[AW-1:0];
                link_wdata = r_cur;
                if (r_prev == NIL) begin
                    n_head = r_free;
                end
                n_free  = r_free_next;
                n_count = PW'(1);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {6'd0, FLD_W'(r_free), FLD_W'(r_head),
                                   FLD_W'(r_count), r_status};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cur       <= '0;
            r_head      <= NIL;
            r_free      <= '0;
            r_prev      <= NIL;
            r_dirty     <= 1'b0;
            r_status    <= ST_DONE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_head      <= n_head;
            r_free      <= n_free;
            r_prev      <= n_prev;
            r_dirty     <= n_dirty;
            r_status    <= n_status;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_value     <= n_value;
        r_repl      <= n_repl;
        r_free_next <= n_free_next;
        r_out_data  <= n_out_data;
    end

    // a slot is never both list head and free head
    a_head_free_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head != NIL) |-> (r_head != r_free))
        else $error("list head and free head point at the same slot");

    // rejected requests change nothing
    a_reject_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status != ST_DONE) |-> (r_count == '0))
        else $error("rejected request reports affected slots");

    // affected count stays within the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL)
        else $error("affected count exceeds slot count");

    // no request taken during the clearing pass
    a_init_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !s_axis_tready)
        else $error("request taken during clearing pass");

endmodule

`default_nettype wire

// ===== sv/cll_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module cll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
